>>> src/tfsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tfsm_pkg;

  localparam int STATE_W    = 8;
  localparam int SYM_W      = 2;
  localparam int COUNT_W    = 32;
  localparam int MAX_STATES = 1 << STATE_W;
  localparam int ALPHABET   = 1 << SYM_W;
  localparam int TBL_ADDR_W = STATE_W + SYM_W;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_RUN     = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch request, table write/read, restart
    logic tbl_step;  // table data back: move state, issue counter read
    logic cnt_step;  // counter data back: build count, write back on run
    logic emit;      // move pending result into output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

>>> src/tfsm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tfsm_req_if
  import tfsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [STATE_W-1:0] state_index;
  logic [SYM_W-1:0]   symbol;
  logic [STATE_W-1:0] next_state;

  modport source (output valid, opcode, state_index, symbol, next_state, input ready);
  modport sink   (input valid, opcode, state_index, symbol, next_state, output ready);
endinterface

interface tfsm_rsp_if
  import tfsm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [STATE_W-1:0] current_state;
  logic [COUNT_W-1:0] count;

  modport source (output valid, current_state, count, input ready);
  modport sink   (input valid, current_state, count, output ready);
endinterface

`default_nettype wire

>>> src/tfsm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tfsm_ctrl
  import tfsm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire logic [1:0] req_opcode,
  output logic            req_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TBL,
    S_CNT,
    S_EMIT
  } state_t;

  state_t state;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && req_valid;
    cmd.tbl_step = (state == S_TBL);
    cmd.cnt_step = (state == S_CNT);
    cmd.emit     = (state == S_EMIT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            unique case (op_t'(req_opcode))
              OP_RUN:  state <= S_TBL;
              OP_READ: state <= S_CNT;
              default: state <= S_EMIT;
            endcase
          end
        end
        S_TBL:  state <= S_CNT;
        S_CNT:  state <= S_EMIT;
        S_EMIT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> src/tfsm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module tfsm_dp
  import tfsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         req_opcode,
  input  wire logic [STATE_W-1:0] req_state_index,
  input  wire logic [SYM_W-1:0]   req_symbol,
  input  wire logic [STATE_W-1:0] req_next_state,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  tfsm_rsp_if.source              rsp
);

  // transition table, no reset; user must load entries a run reads, unchecked
  logic [STATE_W-1:0] tbl_mem [ALPHABET*MAX_STATES];
  logic [STATE_W-1:0] tbl_rdata;

  // entry counters; an entry whose valid bit is clear reads as its reset value
  logic [COUNT_W-1:0]    cnt_mem [MAX_STATES];
  logic [MAX_STATES-1:0] cnt_vld;
  logic [COUNT_W-1:0]    cnt_rdata;
  logic                  cnt_rvld;
  logic [STATE_W-1:0]    cnt_addr;

  logic [STATE_W-1:0] present_state;
  logic [COUNT_W-1:0] pend_count;
  op_t                op;

  logic               is_load;
  logic               is_restart;
  logic               cnt_rd;
  logic [STATE_W-1:0] cnt_raddr;
  logic [COUNT_W-1:0] cnt_eff;
  logic [COUNT_W-1:0] cnt_inc;
  logic               cnt_wr;

  assign is_load    = cmd.capture && (op_t'(req_opcode) == OP_LOAD);
  assign is_restart = cmd.capture && (op_t'(req_opcode) == OP_RESTART);

  // counter read: on capture for read, after table lookup for run
  assign cnt_rd    = cmd.tbl_step || (cmd.capture && (op_t'(req_opcode) == OP_READ));
  assign cnt_raddr = cmd.tbl_step ? tbl_rdata : req_state_index;

  assign cnt_eff = cnt_rvld ? cnt_rdata :
                   ((cnt_addr == '0) ? COUNT_W'(1) : '0);
  assign cnt_inc = (&cnt_eff) ? cnt_eff : cnt_eff + COUNT_W'(1);
  assign cnt_wr  = cmd.cnt_step && (op == OP_RUN);

  assign status.out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (is_load) tbl_mem[{req_state_index, req_symbol}] <= req_next_state;
    tbl_rdata <= tbl_mem[{present_state, req_symbol}];
  end

  always_ff @(posedge clk) begin
    if (cnt_wr) cnt_mem[cnt_addr] <= cnt_inc;
    if (cnt_rd) begin
      cnt_rdata <= cnt_mem[cnt_raddr];
      cnt_addr  <= cnt_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld       <= '0;
      cnt_rvld      <= 1'b0;
      present_state <= '0;
      rsp.valid     <= 1'b0;
    end else begin
      if (is_restart) begin
        cnt_vld       <= '0;
        present_state <= '0;
      end else if (cnt_wr) begin
        cnt_vld[cnt_addr] <= 1'b1;
      end
      if (cnt_rd) cnt_rvld <= cnt_vld[cnt_raddr];
      if (cmd.tbl_step) present_state <= tbl_rdata;
      if (cmd.emit) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op         <= op_t'(req_opcode);
      pend_count <= '0;
    end
    if (cmd.cnt_step) pend_count <= (op == OP_RUN) ? cnt_inc : cnt_eff;
    if (cmd.emit) begin
      rsp.current_state <= present_state;
      rsp.count         <= pend_count;
    end
  end

endmodule

`default_nettype wire

>>> src/table_fsm_with_visit_counters.sv
// Channel  Dir  Handshake        Payload
// req      in   valid / ready    opcode, state_index, symbol, next_state
// rsp      out  valid / ready    current_state, count
//
// Load and restart capture, then emit; read adds a counter read; run adds
// a table read, then a counter read with write-back; emit waits on rsp.
// The controller handles one request at a time; the output register lets
// a new request be taken while the previous result waits.
// Reset (rst, synchronous) sets the state to 0 and clears counter valid
// bits, so counter 0 reads 1 and the rest 0. The table is not reset.
`timescale 1ns / 1ps
`default_nettype none

module table_fsm_with_visit_counters
  import tfsm_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  tfsm_req_if.sink  req,
  tfsm_rsp_if.source rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tfsm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_opcode (req.opcode),
    .req_ready  (req.ready),
    .cmd        (cmd),
    .status     (status)
  );

  tfsm_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .req_opcode      (req.opcode),
    .req_state_index (req.state_index),
    .req_symbol      (req.symbol),
    .req_next_state  (req.next_state),
    .cmd             (cmd),
    .status          (status),
    .rsp             (rsp)
  );

  // one request in flight: no second accept right after one
  a_single_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one in flight");

  // commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.tbl_step, cmd.cnt_step, cmd.emit}))
    else $error("overlapping datapath commands");

  // a result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!rsp.valid || rsp.ready))
    else $error("result emitted over a stalled one");

  // capture only on a real handshake
  a_capture: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (req.valid && req.ready))
    else $error("capture without accepted request");

endmodule

`default_nettype wire
